[rtl/core/dnsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS A-record parser package
// Shared constants, codes and the per-datagram parse state type.
// ----------------------------------------------------------------------------
package dnsp_pkg;

    localparam int MAX_LEN = 1500;
    localparam int POS_W   = $clog2(MAX_LEN + 1);

    // header byte positions
    localparam int HDR_ID_LSB      = 1;
    localparam int HDR_FLAGS       = 2;
    localparam int HDR_RCODE       = 3;
    localparam int HDR_ANCOUNT_LSB = 7;
    localparam int HDR_LAST        = 11;
    localparam int HDR_LEN         = 12;

    // answer fixed part: TYPE, CLASS, TTL, RDLENGTH
    localparam int AF_LEN      = 10;
    localparam int AF_TYPE_LSB = 1;
    localparam int AF_TTL_LSB  = 7;
    localparam int AF_RDLEN_LSB = 9;
    localparam int QF_LEN      = 4;
    localparam int ADDR_LEN    = 4;

    localparam logic [15:0] TYPE_A   = 16'd1;
    localparam logic [7:0]  PTR_MASK = 8'hC0;
    localparam logic [7:0]  TC_MASK  = 8'h02;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_NAME   = 4'd1,
        PH_PTR    = 4'd2,
        PH_LABEL  = 4'd3,
        PH_QFIXED = 4'd4,
        PH_AFIXED = 4'd5,
        PH_RDATA  = 4'd6,
        PH_ADDR   = 4'd7,
        PH_DONE   = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_SHORT     = 3'd1,
        ST_ID        = 3'd2,
        ST_RCODE     = 3'd3,
        ST_NOANS     = 3'd4,
        ST_MALFORMED = 3'd5,
        ST_NOA       = 3'd6
    } status_t;

    typedef struct packed {
        phase_t             phase;
        logic [POS_W-1:0]   pos;
        logic [15:0]        skip;
        logic [15:0]        answers;
        logic [31:0]        shift;
        logic [15:0]        rtype;
        logic [15:0]        rlen;
        logic [31:0]        addr;
        logic [31:0]        ttl;
        status_t            status;
        logic               id_bad;
        logic               tc;
        logic [3:0]         rcode;
        logic               in_answers;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:      PH_HEADER,
        pos:        '0,
        skip:       '0,
        answers:    '0,
        shift:      '0,
        rtype:      '0,
        rlen:       '0,
        addr:       '0,
        ttl:        '0,
        status:     ST_FOUND,
        id_bad:     1'b0,
        tc:         1'b0,
        rcode:      '0,
        in_answers: 1'b0
    };

endpackage

[rtl/core/dnsp_byte_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS A-record parser byte step
// Next parse state for one datagram byte: header checks, name and field
// skipping, answer walk and A-record capture.
// ----------------------------------------------------------------------------
module dnsp_byte_step
    import dnsp_pkg::*;
(
    input  parse_state_t cur_state,
    input  logic [7:0]   data_byte,
    input  logic [15:0]  expected_id,
    output parse_state_t nxt_state
);

    logic [31:0] shifted;
    logic [3:0]  af_index;
    logic [15:0] answers_dec;
    logic        skip_end;

    assign shifted     = {cur_state.shift[23:0], data_byte};
    assign af_index    = 4'(AF_LEN) - cur_state.skip[3:0];
    assign answers_dec = cur_state.answers - 16'd1;
    assign skip_end    = (cur_state.skip == 16'd1);

    always_comb
    begin
        nxt_state = cur_state;
        if (cur_state.pos < POS_W'(MAX_LEN))
        begin
            nxt_state.pos = cur_state.pos + POS_W'(1);
            unique case (cur_state.phase)
                PH_HEADER:
                begin
                    nxt_state.shift = shifted;
                    priority if (cur_state.pos == POS_W'(HDR_ID_LSB))
                        nxt_state.id_bad = (shifted[15:0] != expected_id);
                    else if (cur_state.pos == POS_W'(HDR_FLAGS))
                        nxt_state.tc = ((data_byte & TC_MASK) != 8'd0);
                    else if (cur_state.pos == POS_W'(HDR_RCODE))
                        nxt_state.rcode = data_byte[3:0];
                    else if (cur_state.pos == POS_W'(HDR_ANCOUNT_LSB))
                        nxt_state.answers = shifted[15:0];
                    else if (cur_state.pos == POS_W'(HDR_LAST))
                    begin
                        nxt_state.shift = '0;
                        priority if (cur_state.id_bad)
                        begin
                            nxt_state.status = ST_ID;
                            nxt_state.phase  = PH_DONE;
                        end
                        else if (cur_state.rcode != 4'd0)
                        begin
                            nxt_state.status = ST_RCODE;
                            nxt_state.phase  = PH_DONE;
                        end
                        else if (cur_state.answers == 16'd0)
                        begin
                            nxt_state.status = ST_NOANS;
                            nxt_state.phase  = PH_DONE;
                        end
                        else
                        begin
                            nxt_state.in_answers = 1'b0;
                            nxt_state.phase      = PH_NAME;
                        end
                    end
                    else
                    begin
                    end
                end
                PH_NAME, PH_PTR:
                begin
                    if (cur_state.phase == PH_PTR || data_byte == 8'd0)
                    begin
                        nxt_state.shift = '0;
                        if (cur_state.in_answers)
                        begin
                            nxt_state.phase = PH_AFIXED;
                            nxt_state.skip  = 16'(AF_LEN);
                        end
                        else
                        begin
                            nxt_state.phase = PH_QFIXED;
                            nxt_state.skip  = 16'(QF_LEN);
                        end
                    end
                    else if ((data_byte & PTR_MASK) == PTR_MASK)
                        nxt_state.phase = PH_PTR;
                    else
                    begin
                        nxt_state.skip  = {8'd0, data_byte};
                        nxt_state.phase = PH_LABEL;
                    end
                end
                PH_LABEL:
                begin
                    nxt_state.skip = cur_state.skip - 16'd1;
                    if (skip_end)
                        nxt_state.phase = PH_NAME;
                end
                PH_QFIXED:
                begin
                    nxt_state.skip = cur_state.skip - 16'd1;
                    if (skip_end)
                    begin
                        nxt_state.in_answers = 1'b1;
                        nxt_state.phase      = PH_NAME;
                    end
                end
                PH_AFIXED:
                begin
                    nxt_state.shift = shifted;
                    if (af_index == 4'(AF_TYPE_LSB))
                        nxt_state.rtype = shifted[15:0];
                    if (af_index == 4'(AF_TTL_LSB))
                        nxt_state.ttl = shifted;
                    if (af_index == 4'(AF_RDLEN_LSB))
                        nxt_state.rlen = shifted[15:0];
                    nxt_state.skip = cur_state.skip - 16'd1;
                    if (skip_end)
                    begin
                        nxt_state.shift = '0;
                        priority if (nxt_state.rtype == TYPE_A && nxt_state.rlen == 16'(ADDR_LEN))
                        begin
                            nxt_state.skip  = 16'(ADDR_LEN);
                            nxt_state.phase = PH_ADDR;
                        end
                        else if (nxt_state.rlen == 16'd0)
                        begin
                            nxt_state.answers = answers_dec;
                            if (answers_dec == 16'd0)
                            begin
                                nxt_state.status = ST_NOA;
                                nxt_state.phase  = PH_DONE;
                            end
                            else
                                nxt_state.phase = PH_NAME;
                        end
                        else
                        begin
                            nxt_state.skip  = nxt_state.rlen;
                            nxt_state.phase = PH_RDATA;
                        end
                    end
                end
                PH_RDATA:
                begin
                    nxt_state.skip = cur_state.skip - 16'd1;
                    if (skip_end)
                    begin
                        nxt_state.answers = answers_dec;
                        if (answers_dec == 16'd0)
                        begin
                            nxt_state.status = ST_NOA;
                            nxt_state.phase  = PH_DONE;
                        end
                        else
                            nxt_state.phase = PH_NAME;
                    end
                end
                PH_ADDR:
                begin
                    nxt_state.shift = shifted;
                    nxt_state.skip  = cur_state.skip - 16'd1;
                    if (skip_end)
                    begin
                        nxt_state.addr   = shifted;
                        nxt_state.status = ST_FOUND;
                        nxt_state.phase  = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

[rtl/core/dns_response_a_record_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS response A-record parser
// Parses a DNS response byte stream, checks the header against the query ID
// and reports the first IPv4 A record with its TTL, one result per datagram.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// cfg       cfg_write_en           cfg_write_data (expected query ID)
// in        in_valid / in_ready    data_byte, last_byte
// out       out_valid / out_ready  status, ipv4_address, ttl_seconds,
//                                  truncated, response_code
//
// One byte per cycle sustained unless a pending result stalls the last byte; a byte
// is registered, then parsed by a single update of the parse state.
// The last byte passes the input register, then the result register, before out_valid.
// Reset clears the parse state, the ID register and both valid flags.
// A stalled result holds the last byte in the input register; no further byte is
// accepted until the result is taken.
// ----------------------------------------------------------------------------
module dns_response_a_record_parser
    import dnsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] ipv4_address,
    output logic [31:0] ttl_seconds,
    output logic        truncated,
    output logic [3:0]  response_code
);

    logic [15:0]  expected_id_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    logic [2:0]   status_reg;
    logic [31:0]  ipv4_reg;
    logic [31:0]  ttl_reg;
    logic         tc_reg;
    logic [3:0]   rcode_reg;

    parse_state_t st_reg;
    parse_state_t st_next;
    parse_state_t step_state;
    status_t      result_status;
    logic         advance;
    logic         emit;

    dnsp_byte_step u_step (
        .cur_state   (st_reg),
        .data_byte   (in_byte_reg),
        .expected_id (expected_id_reg),
        .nxt_state   (step_state)
    );

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || out_ready);
    assign emit     = advance && in_last_reg;
    assign in_ready = !in_valid_reg || advance;
    assign st_next  = emit ? STATE_RESET : step_state;

    always_comb
    begin
        if (step_state.phase == PH_DONE)
            result_status = step_state.status;
        else if (step_state.pos < POS_W'(HDR_LEN))
            result_status = ST_SHORT;
        else
            result_status = ST_MALFORMED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expected_id_reg <= '0;
        else if (cfg_write_en)
            expected_id_reg <= cfg_write_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= STATE_RESET;
        else if (advance)
            st_reg <= st_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= result_status;
            ipv4_reg   <= (result_status == ST_FOUND) ? step_state.addr : '0;
            ttl_reg    <= (result_status == ST_FOUND) ? step_state.ttl : '0;
            tc_reg     <= step_state.tc;
            rcode_reg  <= step_state.rcode;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign ipv4_address  = ipv4_reg;
    assign ttl_seconds   = ttl_reg;
    assign truncated     = tc_reg;
    assign response_code = rcode_reg;

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("result not presented after last byte");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (st_reg.phase == PH_HEADER && st_reg.pos == '0))
        else $error("parse state not cleared between datagrams");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.pos <= POS_W'(MAX_LEN))
        else $error("byte position past maximum length");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !emit)
        else $error("pending result overwritten");

    a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_FOUND) |-> (ipv4_reg == '0 && ttl_reg == '0))
        else $error("address or TTL reported without A record");

endmodule
